/* design/pps_pkg.sv */
// ----------------------------------------------------------------------------
// pps_pkg - shared types and constants for the priority scheduler
// Field widths, opcodes, sequencer states, table records and a clamped
// subtract used by the report math.
// ----------------------------------------------------------------------------
package pps_pkg;

  localparam int MAX_TASKS_DFLT = 16;

  localparam int OP_W    = 2;
  localparam int SLOT_W  = 4;
  localparam int ID_W    = 8;
  localparam int TIME_W  = 16;
  localparam int BURST_W = 12;
  localparam int PRIO_W  = 8;
  localparam int PC_W    = 5;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD    = 2'd0,
    OP_TICK    = 2'd1,
    OP_RESTART = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CALC,
    ST_EMIT
  } state_t;

  // static part of a slot, written by a load
  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [TIME_W-1:0]  arrival;
    logic [BURST_W-1:0] burst;
    logic [PRIO_W-1:0]  prio;
  } task_entry_t;

  // run progress of a slot, only meaningful while its started flag is set
  typedef struct packed {
    logic [BURST_W-1:0] served;
    logic [TIME_W-1:0]  first_run;
  } progress_t;

  function automatic logic [TIME_W-1:0] sub_clamp(input logic [TIME_W-1:0] a,
                                                  input logic [TIME_W-1:0] b);
    return (a > b) ? (a - b) : '0;
  endfunction

endpackage

/* design/pps_cmd_if.sv */
// ----------------------------------------------------------------------------
// pps_cmd_if - command channel of the priority scheduler
// Valid/ready channel carrying one command word: load, tick or restart.
// ----------------------------------------------------------------------------
interface pps_cmd_if;
  logic                         valid;
  logic                         ready;
  logic [pps_pkg::OP_W-1:0]     op;
  logic [pps_pkg::SLOT_W-1:0]   slot;
  logic [pps_pkg::ID_W-1:0]     task_id;
  logic [pps_pkg::TIME_W-1:0]   arrival_time;
  logic [pps_pkg::BURST_W-1:0]  burst_length;
  logic [pps_pkg::PRIO_W-1:0]   task_priority;

  modport source (
    output valid, op, slot, task_id, arrival_time, burst_length, task_priority,
    input  ready
  );
  modport sink (
    input  valid, op, slot, task_id, arrival_time, burst_length, task_priority,
    output ready
  );
endinterface

/* design/pps_rpt_if.sv */
// ----------------------------------------------------------------------------
// pps_rpt_if - report channel of the priority scheduler
// Valid/ready channel carrying one report word per tick.
// ----------------------------------------------------------------------------
interface pps_rpt_if;
  logic                        valid;
  logic                        ready;
  logic [pps_pkg::TIME_W-1:0]  tick_time;
  logic                        run_valid;
  logic [pps_pkg::ID_W-1:0]    run_id;
  logic                        finished;
  logic [pps_pkg::TIME_W-1:0]  completion_time;
  logic [pps_pkg::TIME_W-1:0]  turnaround_time;
  logic [pps_pkg::TIME_W-1:0]  waiting_time;
  logic [pps_pkg::TIME_W-1:0]  response_time;
  logic                        all_done;

  modport source (
    output valid, tick_time, run_valid, run_id, finished, completion_time,
           turnaround_time, waiting_time, response_time, all_done,
    input  ready
  );
  modport sink (
    input  valid, tick_time, run_valid, run_id, finished, completion_time,
           turnaround_time, waiting_time, response_time, all_done,
    output ready
  );
endinterface

/* design/pps_ram.sv */
// ----------------------------------------------------------------------------
// pps_ram - generic single-write, single-read RAM
// One write port, one read port with registered read data. No reset.
// ----------------------------------------------------------------------------
module pps_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/preemptive_priority_scheduler_top.sv */
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler_top - preemptive priority task scheduler
// Task table plus a sequencer that walks it once per tick with one shared
// comparator to pick the task to run, then updates its progress and reports.
// ----------------------------------------------------------------------------
// Usage: load slots with op LOAD, set process_count through the cfg port,
// then send TICK words; each TICK yields one report word, LOAD and RESTART
// yield none. A TICK steps the sequencer through IDLE (accept), SCAN (a
// table walk of one slot per cycle through the table RAM read port, whose
// read data is registered), CALC (settle the pick's progress) and EMIT
// (load the report register, waiting while the last report is unread).
// The command side stays ready only while the sequencer is idle; a
// finished report waits in the output register while the next command is
// taken. There is no clearing pass after reset: started/done flags live in
// flops, and a slot's progress entry is ignored (served count taken as zero,
// first run taken as the current time) until its started flag is set.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler_top #(
  parameter int MAX_TASKS = pps_pkg::MAX_TASKS_DFLT
) (
  input  logic                     clk,
  input  logic                     rst,
  pps_cmd_if.sink                  cmd,
  pps_rpt_if.source                rpt,
  input  logic                     cfg_we,
  input  logic [pps_pkg::PC_W-1:0] cfg_wdata
);

  localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam int TW = $bits(pps_pkg::task_entry_t);
  localparam int PW = $bits(pps_pkg::progress_t);

  // --------------------------------------------------------------------------
  // Control state
  // --------------------------------------------------------------------------
  pps_pkg::state_t state, state_next;

  logic [pps_pkg::PC_W-1:0]   process_count;
  logic [CW-1:0]              n_used;
  logic [pps_pkg::TIME_W-1:0] cur_time;
  logic [MAX_TASKS-1:0]       started;
  logic [MAX_TASKS-1:0]       done;

  // table walk
  logic [CW-1:0] scan_cnt;
  logic          cmp_valid;
  logic [AW-1:0] cmp_idx;

  // best candidate so far
  logic                  found;
  logic [AW-1:0]         b_idx;
  pps_pkg::task_entry_t  b_entry;
  pps_pkg::progress_t    b_prog;
  logic                  b_started;
  logic [1:0]            nd_cnt;   // not-done slots in use, saturates at 2

  // per-tick results
  logic                       r_fin;
  logic [pps_pkg::TIME_W-1:0] r_next;
  logic [pps_pkg::TIME_W-1:0] r_turn;
  logic [pps_pkg::TIME_W-1:0] r_first;

  // handshakes
  logic cmd_acc, load_acc, tick_acc, restart_acc, slot_ok, emit_fire;

  assign cmd_acc     = cmd.valid && cmd.ready;
  assign load_acc    = cmd_acc && (cmd.op == pps_pkg::OP_LOAD);
  assign tick_acc    = cmd_acc && (cmd.op == pps_pkg::OP_TICK);
  assign restart_acc = cmd_acc && (cmd.op == pps_pkg::OP_RESTART);
  assign slot_ok     = (32'(cmd.slot) < MAX_TASKS);
  assign emit_fire   = (state == pps_pkg::ST_EMIT) && (!rpt.valid || rpt.ready);

  // counts above the table size act as a full table
  assign n_used = (32'(process_count) > MAX_TASKS) ? CW'(MAX_TASKS) : CW'(process_count);

  // --------------------------------------------------------------------------
  // Table storage
  // --------------------------------------------------------------------------
  pps_pkg::task_entry_t ld_entry, t_rd;
  pps_pkg::progress_t   p_wr, p_rd;
  logic [AW-1:0]        rd_addr;

  assign ld_entry.id      = cmd.task_id;
  assign ld_entry.arrival = cmd.arrival_time;
  assign ld_entry.burst   = cmd.burst_length;
  assign ld_entry.prio    = cmd.task_priority;
  assign rd_addr          = scan_cnt[AW-1:0];

  pps_ram #(.WIDTH(TW), .DEPTH(MAX_TASKS)) u_task_ram (
    .clk   (clk),
    .we    (load_acc && slot_ok),
    .waddr (AW'(cmd.slot)),
    .wdata (ld_entry),
    .raddr (rd_addr),
    .rdata (t_rd)
  );

  pps_ram #(.WIDTH(PW), .DEPTH(MAX_TASKS)) u_prog_ram (
    .clk   (clk),
    .we    ((state == pps_pkg::ST_CALC) && found),
    .waddr (b_idx),
    .wdata (p_wr),
    .raddr (rd_addr),
    .rdata (p_rd)
  );

  // --------------------------------------------------------------------------
  // Shared comparator: one slot per cycle against the current best
  // --------------------------------------------------------------------------
  logic c_done, c_ready, c_better;

  assign c_done   = done[cmp_idx];
  assign c_ready  = !c_done && (t_rd.arrival <= cur_time);
  assign c_better = !found || (t_rd.prio < b_entry.prio) ||
                    ((t_rd.prio == b_entry.prio) && (t_rd.arrival < b_entry.arrival));

  // --------------------------------------------------------------------------
  // Progress math for the picked slot
  // --------------------------------------------------------------------------
  logic [pps_pkg::BURST_W-1:0] served_eff;
  logic [pps_pkg::BURST_W:0]   served_inc;
  logic                        finish;
  logic [pps_pkg::TIME_W-1:0]  first_eff;

  assign served_eff = b_started ? b_prog.served : '0;
  assign served_inc = {1'b0, served_eff} + 1'b1;
  // a zero burst finishes on its first tick, like a burst of one
  assign finish     = (served_inc >= {1'b0, b_entry.burst});
  assign first_eff  = b_started ? b_prog.first_run : cur_time;

  assign p_wr.served    = served_inc[pps_pkg::BURST_W-1:0];
  assign p_wr.first_run = first_eff;

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pps_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.ready  = 1'b0;
    unique case (state)
      pps_pkg::ST_IDLE: begin
        cmd.ready = 1'b1;
        if (cmd.valid && (cmd.op == pps_pkg::OP_TICK)) begin
          state_next = pps_pkg::ST_SCAN;
        end
      end
      pps_pkg::ST_SCAN: begin
        // last compare happens in the cycle the counter reaches the count
        if (scan_cnt == n_used) begin
          state_next = pps_pkg::ST_CALC;
        end
      end
      pps_pkg::ST_CALC: begin
        state_next = pps_pkg::ST_EMIT;
      end
      pps_pkg::ST_EMIT: begin
        if (emit_fire) begin
          state_next = pps_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = pps_pkg::ST_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      process_count <= '0;
      cur_time      <= '0;
      started       <= '0;
      done          <= '0;
      cmp_valid     <= 1'b0;
      found         <= 1'b0;
      nd_cnt        <= '0;
      rpt.valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        process_count <= cfg_wdata;
      end

      cmp_valid <= (state == pps_pkg::ST_SCAN) && (scan_cnt < n_used);

      if (load_acc && slot_ok) begin
        started[AW'(cmd.slot)] <= 1'b0;
        done[AW'(cmd.slot)]    <= 1'b0;
      end

      // restart: progress entries become stale once started drops
      if (restart_acc) begin
        cur_time <= '0;
        started  <= '0;
        done     <= '0;
      end

      if (tick_acc) begin
        found  <= 1'b0;
        nd_cnt <= '0;
      end

      if (cmp_valid) begin
        if (!c_done && (nd_cnt != 2'd2)) begin
          nd_cnt <= nd_cnt + 1'b1;
        end
        if (c_ready && c_better) begin
          found <= 1'b1;
        end
      end

      if ((state == pps_pkg::ST_CALC) && found) begin
        started[b_idx] <= 1'b1;
        if (finish) begin
          done[b_idx] <= 1'b1;
        end
      end

      if (emit_fire) begin
        cur_time  <= r_next;
        rpt.valid <= 1'b1;
      end else if (rpt.ready) begin
        rpt.valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (tick_acc) begin
      scan_cnt <= '0;
      r_next   <= (cur_time == pps_pkg::TIME_MAX) ? cur_time : cur_time + 1'b1;
    end else if ((state == pps_pkg::ST_SCAN) && (scan_cnt < n_used)) begin
      scan_cnt <= scan_cnt + 1'b1;
    end

    cmp_idx <= rd_addr;

    if (cmp_valid && c_ready && c_better) begin
      b_idx     <= cmp_idx;
      b_entry   <= t_rd;
      b_prog    <= p_rd;
      b_started <= started[cmp_idx];
    end

    if (state == pps_pkg::ST_CALC) begin
      r_fin   <= found && finish;
      r_turn  <= pps_pkg::sub_clamp(r_next, b_entry.arrival);
      r_first <= first_eff;
    end

    if (emit_fire) begin
      rpt.tick_time <= cur_time;
      rpt.run_valid <= found;
      rpt.run_id    <= found ? b_entry.id : '0;
      rpt.finished  <= r_fin;
      if (r_fin) begin
        rpt.completion_time <= r_next;
        rpt.turnaround_time <= r_turn;
        rpt.waiting_time    <= pps_pkg::sub_clamp(r_turn,
                                 pps_pkg::TIME_W'(b_entry.burst));
        rpt.response_time   <= pps_pkg::sub_clamp(r_first, b_entry.arrival);
      end else begin
        rpt.completion_time <= '0;
        rpt.turnaround_time <= '0;
        rpt.waiting_time    <= '0;
        rpt.response_time   <= '0;
      end
      // all done when no slot in use was open, or the picked slot was the last open one
      rpt.all_done <= (nd_cnt == 2'd0) || ((nd_cnt == 2'd1) && r_fin);
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_tick_starts_scan: assert property (@(posedge clk) disable iff (rst)
    tick_acc |=> (state == pps_pkg::ST_SCAN))
    else $error("tick accepted but walk did not start");

  a_pick_not_done: assert property (@(posedge clk) disable iff (rst)
    ((state == pps_pkg::ST_CALC) && found) |-> !done[b_idx])
    else $error("picked a slot that is already done");

  a_done_implies_started: assert property (@(posedge clk) disable iff (rst)
    ((done & ~started) == '0))
    else $error("slot done without having started");

  a_time_monotonic: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> ((cur_time >= $past(cur_time)) || $past(restart_acc)))
    else $error("time went backwards without a restart");

endmodule

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb - self-checking bench for the preemptive priority scheduler
// Streams load, tick and restart words into the command channel. A local
// copy of the task table predicts every report word, and the bench checks
// each report against it in order. The run covers several process_count
// settings and random stalls on both channels.
// ----------------------------------------------------------------------------
module tb;

  localparam int NSLOT       = pps_pkg::MAX_TASKS_DFLT;
  localparam int STALL_LIMIT = 3000;   // cycles with no word moving on either side
  localparam int SETTLE_CYC  = 40;     // slack for a trailing word to retire
  localparam int PHASE_WORDS = 220;
  // no such command, must be dropped
  localparam logic [pps_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [pps_pkg::OP_W-1:0]    op;
    logic [pps_pkg::SLOT_W-1:0]  slot;
    logic [pps_pkg::ID_W-1:0]    task_id;
    logic [pps_pkg::TIME_W-1:0]  arrival;
    logic [pps_pkg::BURST_W-1:0] burst;
    logic [pps_pkg::PRIO_W-1:0]  prio;
  } cmd_word_t;

  typedef struct packed {
    logic [pps_pkg::TIME_W-1:0] tick_time;
    logic                       run_valid;
    logic [pps_pkg::ID_W-1:0]   run_id;
    logic                       finished;
    logic [pps_pkg::TIME_W-1:0] completion;
    logic [pps_pkg::TIME_W-1:0] turnaround;
    logic [pps_pkg::TIME_W-1:0] waiting;
    logic [pps_pkg::TIME_W-1:0] response;
    logic                       all_done;
  } report_t;

  logic                     clk;
  logic                     rst;
  logic                     cfg_we;
  logic [pps_pkg::PC_W-1:0] cfg_wdata;

  pps_cmd_if cmd_ch ();
  pps_rpt_if rpt_ch ();

  preemptive_priority_scheduler_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_ch),
    .rpt       (rpt_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // Shadow task table: what the scheduler should hold after each word
  // --------------------------------------------------------------------------
  logic [pps_pkg::ID_W-1:0]    tbl_id      [NSLOT];
  logic [pps_pkg::TIME_W-1:0]  tbl_arrival [NSLOT];
  logic [pps_pkg::BURST_W-1:0] tbl_burst   [NSLOT];
  logic [pps_pkg::PRIO_W-1:0]  tbl_prio    [NSLOT];
  logic [pps_pkg::BURST_W-1:0] tbl_left    [NSLOT];
  logic                        tbl_started [NSLOT];
  logic                        tbl_done    [NSLOT];
  logic [pps_pkg::TIME_W-1:0]  tbl_first   [NSLOT];
  logic [pps_pkg::TIME_W-1:0]  sched_time;
  logic [pps_pkg::PC_W-1:0]    slots_in_use;

  cmd_word_t pending_q [$];   // words waiting for the driver
  report_t   report_q  [$];   // predicted report words, oldest first

  int snd_idle_pct;
  int rcv_idle_pct;
  int queued_total;
  int accepted_total;
  int fail_count;
  int stall_cycles;
  int tick_reports;
  int finish_reports;
  int idle_reports;
  bit cmd_taken;
  cmd_word_t drv_word;

  function automatic logic [pps_pkg::TIME_W-1:0] floor_diff(
      input logic [pps_pkg::TIME_W-1:0] a,
      input logic [pps_pkg::TIME_W-1:0] b);
    return (a > b) ? a - b : '0;
  endfunction

  task automatic flag_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("[%0t] ERROR: %s", $realtime, msg);
  endtask

  // Advance the shadow table by one accepted word; ticks queue a report.
  task automatic apply_word(input cmd_word_t w);
    int        used;
    int        pick;
    bit        found;
    logic [pps_pkg::TIME_W-1:0] nxt;
    logic [pps_pkg::TIME_W-1:0] turn;
    report_t   r;
    if (w.op == pps_pkg::OP_LOAD) begin
      tbl_id[w.slot]      = w.task_id;
      tbl_arrival[w.slot] = w.arrival;
      tbl_burst[w.slot]   = w.burst;
      tbl_prio[w.slot]    = w.prio;
      tbl_left[w.slot]    = w.burst;
      tbl_started[w.slot] = 1'b0;
      tbl_done[w.slot]    = 1'b0;
    end else if (w.op == pps_pkg::OP_RESTART) begin
      sched_time = '0;
      for (int i = 0; i < NSLOT; i++) begin
        tbl_started[i] = 1'b0;
        tbl_done[i]    = 1'b0;
        tbl_left[i]    = tbl_burst[i];
      end
    end else if (w.op == pps_pkg::OP_TICK) begin
      used  = (slots_in_use > NSLOT) ? NSLOT : slots_in_use;
      found = 1'b0;
      pick  = 0;
      // lowest priority value wins, then earlier arrival, then lower slot
      for (int i = 0; i < used; i++) begin
        if (tbl_done[i] || tbl_arrival[i] > sched_time) continue;
        if (!found || tbl_prio[i] < tbl_prio[pick] ||
            (tbl_prio[i] == tbl_prio[pick] && tbl_arrival[i] < tbl_arrival[pick])) begin
          found = 1'b1;
          pick  = i;
        end
      end
      nxt = (sched_time == pps_pkg::TIME_MAX) ? sched_time : sched_time + 1'b1;
      r = '0;
      r.tick_time = sched_time;
      if (found) begin
        r.run_valid = 1'b1;
        r.run_id    = tbl_id[pick];
        if (!tbl_started[pick]) begin
          tbl_started[pick] = 1'b1;
          tbl_first[pick]   = sched_time;
        end
        // a zero burst still takes one tick
        if (tbl_left[pick] <= 1) begin
          tbl_left[pick] = '0;
          tbl_done[pick] = 1'b1;
          turn           = floor_diff(nxt, tbl_arrival[pick]);
          r.finished     = 1'b1;
          r.completion   = nxt;
          r.turnaround   = turn;
          r.waiting      = floor_diff(turn, pps_pkg::TIME_W'(tbl_burst[pick]));
          r.response     = floor_diff(tbl_first[pick], tbl_arrival[pick]);
        end else begin
          tbl_left[pick] = tbl_left[pick] - 1'b1;
        end
      end
      sched_time = nxt;
      r.all_done = 1'b1;
      for (int i = 0; i < used; i++) if (!tbl_done[i]) r.all_done = 1'b0;
      report_q = {report_q, r};
    end
    // OP_UNUSED: dropped, nothing changes
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic push_word(input cmd_word_t w);
    pending_q = {pending_q, w};
    queued_total++;
  endtask

  task automatic push_op(input logic [pps_pkg::OP_W-1:0] op);
    cmd_word_t w;
    w = $bits(cmd_word_t)'({$urandom, $urandom});
    w.op = op;
    push_word(w);
  endtask

  task automatic push_load(input int s, input logic [pps_pkg::ID_W-1:0] id,
                           input logic [pps_pkg::TIME_W-1:0] arr,
                           input logic [pps_pkg::BURST_W-1:0] bl,
                           input logic [pps_pkg::PRIO_W-1:0] pr);
    cmd_word_t w;
    w.op      = pps_pkg::OP_LOAD;
    w.slot    = pps_pkg::SLOT_W'(s);
    w.task_id = id;
    w.arrival = arr;
    w.burst   = bl;
    w.prio    = pr;
    push_word(w);
  endtask

  // Mostly early arrivals and short bursts so runs complete; now and then a
  // far arrival or a long burst to reach the top bits.
  function automatic cmd_word_t random_task(input int s);
    cmd_word_t w;
    w.op      = pps_pkg::OP_LOAD;
    w.slot    = pps_pkg::SLOT_W'(s);
    w.task_id = pps_pkg::ID_W'($urandom_range(255));
    w.arrival = pps_pkg::TIME_W'(($urandom_range(19) == 0) ? $urandom_range(65535)
                                                           : $urandom_range(10));
    w.burst   = pps_pkg::BURST_W'(($urandom_range(24) == 0) ? $urandom_range(1, 4095)
                                                            : $urandom_range(1, 6));
    w.prio    = pps_pkg::PRIO_W'($urandom_range(1) ? $urandom_range(3)
                                                   : $urandom_range(255));
    return w;
  endfunction

  // One scheduling run: fill the used slots, restart, then tick for a span
  // estimated from the bursts and arrivals (at most 90 ticks), with the odd mid-run load, restart or bogus op mixed in.
  task automatic queue_run(input int used, output int words);
    int        span;
    int        ticks;
    int        roll;
    cmd_word_t w;
    span  = 0;
    words = 0;
    for (int s = 0; s < used; s++) begin
      w = random_task(s);
      push_word(w);
      words++;
      span += (w.burst > 8) ? 8 : w.burst;
      if (w.arrival < 16) span += w.arrival;
    end
    push_op(pps_pkg::OP_RESTART);
    ticks = span + $urandom_range(1, 4);
    if (ticks > 90) ticks = 90;
    if (used == 0) ticks = $urandom_range(4, 12);
    words += ticks + 1;
    for (int t = 0; t < ticks; t++) begin
      push_op(pps_pkg::OP_TICK);
      roll = $urandom_range(99);
      if (roll < 3) begin
        push_word(random_task($urandom_range(NSLOT - 1)));
        words++;
      end else if (roll == 3) begin
        push_op(pps_pkg::OP_RESTART);
        words++;
      end else if (roll == 4) begin
        push_op(OP_UNUSED);
        words++;
      end
    end
  endtask

  // Block must be idle: all words in, all reports out, and enough slack for a
  // trailing load or restart (no report) to retire.
  task automatic wait_idle();
    while (accepted_total != queued_total || report_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_count(input logic [pps_pkg::PC_W-1:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    slots_in_use = v;
  endtask

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Driver: command words and report-side ready change on the falling edge
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      cmd_ch.valid <= 1'b0;
      rpt_ch.ready <= 1'b0;
    end else begin
      rpt_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
      // only move on once the current word has been taken
      if (!cmd_ch.valid || cmd_taken) begin
        if (pending_q.size() > 0 && $urandom_range(99) >= snd_idle_pct) begin
          drv_word = pending_q.pop_front();
          cmd_ch.op            <= drv_word.op;
          cmd_ch.slot          <= drv_word.slot;
          cmd_ch.task_id       <= drv_word.task_id;
          cmd_ch.arrival_time  <= drv_word.arrival;
          cmd_ch.burst_length  <= drv_word.burst;
          cmd_ch.task_priority <= drv_word.prio;
          cmd_ch.valid         <= 1'b1;
        end else begin
          cmd_ch.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks reports, feeds the shadow table, runs the watchdog
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    report_t   got;
    report_t   want;
    cmd_word_t seen;
    if (rst) begin
      cmd_taken    <= 1'b0;
      stall_cycles = 0;
    end else begin
      cmd_taken <= cmd_ch.valid && cmd_ch.ready;
      // reports first: a report always belongs to an earlier tick
      if (rpt_ch.valid && rpt_ch.ready) begin
        got = {rpt_ch.tick_time, rpt_ch.run_valid, rpt_ch.run_id, rpt_ch.finished,
               rpt_ch.completion_time, rpt_ch.turnaround_time, rpt_ch.waiting_time,
               rpt_ch.response_time, rpt_ch.all_done};
        tick_reports++;
        if (got.finished) finish_reports++;
        if (!got.run_valid) idle_reports++;
        if (report_q.size() == 0) begin
          flag_failure($sformatf("report with no tick pending: %p", got));
        end else begin
          want = report_q.pop_front();
          if (got !== want)
            flag_failure($sformatf({"report mismatch\n  exp t=%0d run=%b id=%0d fin=%b ",
                                    "cmp=%0d tat=%0d wt=%0d rsp=%0d all=%b\n",
                                    "  got t=%0d run=%b id=%0d fin=%b ",
                                    "cmp=%0d tat=%0d wt=%0d rsp=%0d all=%b"},
                                   want.tick_time, want.run_valid, want.run_id,
                                   want.finished, want.completion, want.turnaround,
                                   want.waiting, want.response, want.all_done,
                                   got.tick_time, got.run_valid, got.run_id,
                                   got.finished, got.completion, got.turnaround,
                                   got.waiting, got.response, got.all_done));
        end
      end
      if (cmd_ch.valid && cmd_ch.ready) begin
        seen.op      = cmd_ch.op;
        seen.slot    = cmd_ch.slot;
        seen.task_id = cmd_ch.task_id;
        seen.arrival = cmd_ch.arrival_time;
        seen.burst   = cmd_ch.burst_length;
        seen.prio    = cmd_ch.task_priority;
        apply_word(seen);
        accepted_total++;
      end
      // watchdog: any word moving on either side resets it
      if ((cmd_ch.valid && cmd_ch.ready) || (rpt_ch.valid && rpt_ch.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("[%0t] watchdog: no traffic for %0d cycles", $realtime, STALL_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    int          pcs [6];
    int          words;
    int          run_words;
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    cmd_ch.valid   = 1'b0;
    cmd_ch.op      = pps_pkg::OP_LOAD;
    cmd_ch.slot    = '0;
    cmd_ch.task_id = '0;
    cmd_ch.arrival_time  = '0;
    cmd_ch.burst_length  = '0;
    cmd_ch.task_priority = '0;
    rpt_ch.ready   = 1'b0;
    sched_time     = '0;
    slots_in_use   = '0;
    for (int i = 0; i < NSLOT; i++) begin
      tbl_started[i] = 1'b0;
      tbl_done[i]    = 1'b0;
    end
    snd_idle_pct = 13;
    rcv_idle_pct = 81;
    pcs = '{16, 3, 31, 1, 0, 9};

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // ---- directed: every slot gets written here so no later tick reads
    //      an empty slot, whatever count is in force
    write_count(5'd4);
    push_load(0, 8'h11, 16'd0, 12'd2, 8'd5);       // ties slot 1 on prio and arrival
    push_load(1, 8'hFF, 16'd0, 12'd1, 8'd5);
    push_load(2, 8'h00, 16'd1, 12'd0, 8'd0);       // zero burst, preempts at t=1
    push_load(3, 8'h33, 16'd0, 12'd3, 8'hFF);      // lowest urgency, runs last
    for (int s = 4; s < NSLOT - 1; s++)
      push_load(s, pps_pkg::ID_W'(s), pps_pkg::TIME_W'($urandom_range(3)),
                pps_pkg::BURST_W'($urandom_range(1, 3)),
                pps_pkg::PRIO_W'($urandom_range(255)));
    push_load(NSLOT - 1, 8'hC7, 16'hFFFF, 12'hFFF, 8'h00);  // never arrives
    push_op(OP_UNUSED);
    repeat (9) push_op(pps_pkg::OP_TICK);          // last one lands after all done
    push_op(pps_pkg::OP_RESTART);
    repeat (2) push_op(pps_pkg::OP_TICK);
    wait_idle();

    // ---- random phases, one count setting each
    for (int p = 0; p < 6; p++) begin
      if (p == 2) begin
        snd_idle_pct = 81;
        rcv_idle_pct = 13;
      end else if (p == 4) begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      write_count(pps_pkg::PC_W'(pcs[p]));
      words = 0;
      while (words < PHASE_WORDS) begin
        queue_run((pcs[p] > NSLOT) ? NSLOT : pcs[p], run_words);
        words += run_words;
      end
      wait_idle();
    end

    if (report_q.size() != 0)
      flag_failure($sformatf("%0d predicted reports never arrived", report_q.size()));
    $display("Run covered %0d command words and %0d tick reports (%0d completions, %0d idle)",
             accepted_total, tick_reports, finish_reports, idle_reports);
    $display("process_count 0, 1, 3, 4, 9, 16, 31 under mixed stalls; %0d failures",
             fail_count);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
